[rtl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg: shared definitions for the sorted list table
// Sizes, operation and status codes, controller/datapath link types and
// small helper functions.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_REMOVED  = 3'd1,
		ST_FOUND    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic cmp;
		logic upd;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             res_busy;
		logic [CNT_W-1:0] count;
	} dp_sts_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [IDX_W-1:0] first_one(input logic [DEPTH-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

	// Reduces a count to the five bits of the result fields.
	function automatic logic [4:0] to_out5(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[4:0];
	endfunction

endpackage

[rtl/slt_req_if.sv]
// ----------------------------------------------------------------------------
// slt_req_if: request channel of the sorted list table
// Carries one operation and its value per item under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slt_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [31:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

[rtl/slt_rsp_if.sv]
// ----------------------------------------------------------------------------
// slt_rsp_if: response channel of the sorted list table
// Carries status, position and entry count per item under a valid/ready
// handshake.
// ----------------------------------------------------------------------------
interface slt_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [4:0] position;
	logic [4:0] count;

	modport source (output valid, output status, output position, output count,
		input ready);
	modport sink (input valid, input status, input position, input count,
		output ready);
endinterface

[rtl/slt_ctrl.sv]
// ----------------------------------------------------------------------------
// slt_ctrl: controller of the sorted list table
// Sequences capture, compare and update for one item at a time.
// ----------------------------------------------------------------------------
module slt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  slt_pkg::dp_sts_t sts,
	output slt_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nx    = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp  = 1'b1;
				state_nx = S_UPD;
			end
			S_UPD: begin
				// The result register must be free before the table changes.
				if (!sts.res_busy) begin
					cmd.upd  = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/slt_dp.sv]
// ----------------------------------------------------------------------------
// slt_dp: datapath of the sorted list table
// Holds the ordered entries, compares all of them against the key, shifts
// them on insert or remove and keeps the result register.
// ----------------------------------------------------------------------------
module slt_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slt_pkg::dp_cmd_t       cmd,
	output slt_pkg::dp_sts_t       sts,
	input  logic [1:0]             in_op,
	input  logic signed [31:0]     in_value,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [2:0]             res_status,
	output logic [4:0]             res_position,
	output logic [4:0]             res_count
);

	localparam int N  = slt_pkg::DEPTH;
	localparam int IW = slt_pkg::IDX_W;
	localparam int CW = slt_pkg::CNT_W;

	logic [1:0]                        op_q;
	logic signed [slt_pkg::VAL_W-1:0]  key_q;
	logic signed [slt_pkg::VAL_W-1:0]  entry_q [N];
	logic signed [slt_pkg::VAL_W-1:0]  entry_nx [N];
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_nx;
	logic [N-1:0]                      lt_c;
	logic [N-1:0]                      eq_c;
	logic [N-1:0]                      lt_s1;
	logic [N-1:0]                      eq_s1;
	logic [IW-1:0]                     hit_idx;
	logic                              hit;
	logic                              full;
	logic                              empty;
	logic                              wr_en;
	logic [2:0]                        status_nx;
	logic [CW-1:0]                     pos_nx;
	logic                              res_valid_q;
	logic [2:0]                        status_q;
	logic [4:0]                        pos_q;
	logic [4:0]                        rcount_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= in_op;
			key_q <= in_value;
		end
	end

	// Every cell compares its entry with the key; unused cells never match.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			lt_c[i] = (CW'(i) < count_q) && (entry_q[i] < key_q);
			eq_c[i] = (CW'(i) < count_q) && (entry_q[i] == key_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			lt_s1 <= lt_c;
			eq_s1 <= eq_c;
		end
	end

	assign hit_idx = slt_pkg::first_one(eq_s1);
	assign hit     = |eq_s1;
	assign full    = (count_q == CW'(N));
	assign empty   = (count_q == '0);

	always_comb begin
		for (int j = 0; j < N; j++) begin
			entry_nx[j] = entry_q[j];
		end
		wr_en     = 1'b0;
		count_nx  = count_q;
		pos_nx    = '0;
		status_nx = slt_pkg::ST_NOTFOUND;
		unique case (op_q)
			slt_pkg::OP_INSERT: begin
				if (full) begin
					status_nx = slt_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					count_nx  = count_q + CW'(1);
					status_nx = slt_pkg::ST_INSERTED;
					// Lower entries stay; the key lands on the first cell
					// that is not less; the rest move up by one.
					if (!lt_s1[0]) begin
						entry_nx[0] = key_q;
					end
					for (int j = 1; j < N; j++) begin
						if (!lt_s1[j]) begin
							entry_nx[j] = lt_s1[j-1] ? key_q : entry_q[j-1];
						end
					end
				end
			end
			slt_pkg::OP_REMOVE: begin
				if (empty) begin
					status_nx = slt_pkg::ST_EMPTY;
				end else if (hit) begin
					wr_en     = 1'b1;
					count_nx  = count_q - CW'(1);
					status_nx = slt_pkg::ST_REMOVED;
					for (int j = 0; j < N - 1; j++) begin
						if (IW'(j) >= hit_idx) begin
							entry_nx[j] = entry_q[j+1];
						end
					end
				end
			end
			default: begin
				if (empty) begin
					status_nx = slt_pkg::ST_EMPTY;
				end else if (hit) begin
					status_nx = slt_pkg::ST_FOUND;
					pos_nx    = CW'(hit_idx) + CW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && wr_en) begin
			for (int j = 0; j < N; j++) begin
				entry_q[j] <= entry_nx[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.upd) begin
				count_q     <= count_nx;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			status_q <= status_nx;
			pos_q    <= slt_pkg::to_out5(pos_nx);
			rcount_q <= slt_pkg::to_out5(count_nx);
		end
	end

	assign sts.res_busy = res_valid_q && !res_ready;
	assign sts.count    = count_q;
	assign res_valid    = res_valid_q;
	assign res_status   = status_q;
	assign res_position = pos_q;
	assign res_count    = rcount_q;

endmodule

[rtl/sorted_list_table.sv]
// ----------------------------------------------------------------------------
// sorted_list_table: ordered table of signed 32-bit values
// Insert, remove and search on a table of up to DEPTH entries held in
// ascending order, with one result item per request item.
// ----------------------------------------------------------------------------
// Each request item (op, value) produces exactly one response item
// (status, position, count). An insert places the value in front of the
// first stored value that is not less than it, so equal values end up in
// reverse arrival order; an insert into a full table is dropped with
// status full. A remove deletes the first equal entry, and a search
// reports its 1-based position; both report empty on an empty table and
// not found when no entry matches. The operation code 3 acts as a search.
// The count field is the number of entries after the operation; position
// is zero except for a successful search. The item is captured at the edge
// that accepts it; the controller then passes through a compare state, in
// which every table cell compares its entry against the key, and an update
// state, in which the cells shift and the result register is loaded. A new
// item is accepted only when the controller is back in its idle state. The
// response sits in its own register, so the next request is accepted while
// an earlier response still waits; the update step holds only when that
// register is still occupied.
// ----------------------------------------------------------------------------
module sorted_list_table (
	input  logic       clk,
	input  logic       arst_n,
	slt_req_if.sink    req,
	slt_rsp_if.source  rsp
);

	slt_pkg::dp_cmd_t cmd;
	slt_pkg::dp_sts_t sts;
	logic             in_ready;

	// The controller walks each item through capture, compare and update.
	slt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	// The datapath owns the table, its fill count and the result register.
	slt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_op        (req.op),
		.in_value     (req.value),
		.res_valid    (rsp.valid),
		.res_ready    (rsp.ready),
		.res_status   (rsp.status),
		.res_position (rsp.position),
		.res_count    (rsp.count)
	);

	// The fill count never passes the table size.
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= slt_pkg::CNT_W'(slt_pkg::DEPTH))
		else $error("fill count exceeds table size");

	// An update always presents a response in the next cycle.
	a_upd_to_rsp : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> rsp.valid)
		else $error("update did not produce a response");

	// Only a successful search reports a nonzero position.
	a_pos_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != slt_pkg::ST_FOUND) |-> rsp.position == 5'd0)
		else $error("nonzero position without a found status");

	// No request is taken while the update is made.
	a_no_accept_busy : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !req.ready)
		else $error("request accepted during update");

endmodule

[bench/sorted_list_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_table_checker: scoreboard for the sorted list table
// Watches both channels and keeps its own ordered copy of the table. It
// works out the result of every accepted request and compares each accepted
// response with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sorted_list_table_checker (
	input  logic clk,
	input  logic arst_n,
	slt_req_if   req,
	slt_rsp_if   rsp,
	output int   fails,
	output int   pending
);

	typedef struct packed {
		slt_pkg::status_t status;
		logic [4:0]       position;
		logic [4:0]       count;
	} table_result_t;

	// Mirror of the table, kept in ascending signed order.
	logic signed [slt_pkg::VAL_W-1:0] table_vals [slt_pkg::DEPTH];
	int                               fill_level = 0;
	table_result_t                    expected_results [$];

	// Applies one operation to the mirror and returns the response it causes.
	function automatic table_result_t apply_table_op(input logic [1:0] op,
		input logic signed [slt_pkg::VAL_W-1:0] val);
		table_result_t res;
		int            slot;
		int            j;
		res.status   = slt_pkg::ST_NOTFOUND;
		res.position = '0;
		slot         = 0;
		if (op == slt_pkg::OP_INSERT) begin
			if (fill_level >= slt_pkg::DEPTH) begin
				res.status = slt_pkg::ST_FULL;
			end else begin
				while (slot < fill_level && table_vals[slot] < val) begin
					slot++;
				end
				for (j = fill_level; j > slot; j--) begin
					table_vals[j] = table_vals[j - 1];
				end
				table_vals[slot] = val;
				fill_level++;
				res.status = slt_pkg::ST_INSERTED;
			end
		end else if (fill_level == 0) begin
			res.status = slt_pkg::ST_EMPTY;
		end else begin
			while (slot < fill_level && table_vals[slot] != val) begin
				slot++;
			end
			if (slot < fill_level) begin
				if (op == slt_pkg::OP_REMOVE) begin
					for (j = slot; j + 1 < fill_level; j++) begin
						table_vals[j] = table_vals[j + 1];
					end
					fill_level--;
					res.status = slt_pkg::ST_REMOVED;
				end else begin
					// Both the search code and the unused code end up here.
					res.status   = slt_pkg::ST_FOUND;
					res.position = 5'(slot + 1);
				end
			end
		end
		res.count = 5'(fill_level);
		return res;
	endfunction

	always @(posedge clk) begin
		table_result_t want;
		if (!arst_n) begin
			fill_level = 0;
			expected_results.delete();
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_table_op(req.op, req.value));
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("response item with no request waiting: status %0d", rsp.status);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fails++;
					end
					if (rsp.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, rsp.position);
						fails++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						fails++;
					end
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

[bench/sorted_list_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_table_tb: top of the sorted list table testbench
// Drives request items, stalls the response side at random and gives the
// verdict; the checker beside the block does all prediction and comparing.
// ----------------------------------------------------------------------------
module sorted_list_table_tb;

	// The operation code with no meaning of its own; the block treats it as
	// a search.
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         POOL_SIZE  = 12;
	localparam int         PHASES     = 28;
	localparam int         PHASE_LEN  = 40;
	localparam int         QUIET_LAST = 3;
	localparam int         CYCLE_CAP  = 400000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// Every input of the block is held in a local variable so that it has a
	// known value from time zero and exactly one process drives it.
	logic                             req_valid = 1'b0;
	logic [1:0]                       req_op    = slt_pkg::OP_INSERT;
	logic signed [slt_pkg::VAL_W-1:0] req_value = '0;
	logic                             rsp_ready = 1'b0;

	slt_req_if req_ch ();
	slt_rsp_if rsp_ch ();

	assign req_ch.valid = req_valid;
	assign req_ch.op    = req_op;
	assign req_ch.value = req_value;
	assign rsp_ch.ready = rsp_ready;

	int fail_count;
	int pending_count;

	sorted_list_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sorted_list_table_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.fails   (fail_count),
		.pending (pending_count)
	);

	// Chances, in percent, that a new idle burst starts on either side. Each
	// phase picks its own, and zero gives stretches with no idling at all.
	int unsigned send_gap_pct    = 0;
	int unsigned ready_stall_pct = 0;
	int          stall_left      = 0;

	// The response side drops ready in random bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (ready_stall_pct != 0 && $urandom_range(99) < ready_stall_pct) begin
			rsp_ready <= 1'b0;
			stall_left <= $urandom_range(3);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Watchdog: a hung handshake or a lost response ends the run here.
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("sorted_list_table_tb NOT OK");
			$finish;
		end
	end

	// Values are mostly drawn from a small pool that changes per phase, so
	// removes and searches hit stored entries and duplicates pile up.
	logic signed [slt_pkg::VAL_W-1:0] value_pool [POOL_SIZE];
	int                               pool_len = POOL_SIZE;

	task automatic refresh_pool();
		int i;
		pool_len = $urandom_range(POOL_SIZE, 3);
		for (i = 0; i < POOL_SIZE; i++) begin
			// Half the pool is small numbers around zero, half is full range.
			if ($urandom_range(1) == 0) begin
				value_pool[i] = $signed(32'($urandom_range(16))) - 8;
			end else begin
				value_pool[i] = $urandom;
			end
		end
	endtask

	function automatic logic signed [slt_pkg::VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) begin
			return value_pool[$urandom_range(pool_len - 1)];
		end else if (r < 80) begin
			case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// Picks an operation with the given insert and remove weights; the rest
	// are searches, a few of them under the unused code.
	function automatic logic [1:0] pick_op(input int unsigned ins_pct,
		input int unsigned rem_pct);
		int unsigned r;
		r = $urandom_range(99);
		if (r < ins_pct) begin
			return slt_pkg::OP_INSERT;
		end else if (r < ins_pct + rem_pct) begin
			return slt_pkg::OP_REMOVE;
		end else if ($urandom_range(7) == 0) begin
			return OP_UNUSED;
		end
		return slt_pkg::OP_SEARCH;
	endfunction

	// Presents one item at a falling edge, after an optional idle burst, and
	// returns right after the rising edge at which it was accepted. Valid is
	// left high so that back-to-back items need no extra assignment.
	task automatic send_item(input logic [1:0] op,
		input logic signed [slt_pkg::VAL_W-1:0] val);
		int gap;
		gap = 0;
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			gap = $urandom_range(4, 1);
		end
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_op    <= op;
		req_value <= val;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
	endtask

	// Holds the sender off until every response has come back. Valid goes
	// low first so the last item is not taken twice.
	task automatic wait_for_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_count != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		int          phase;
		int          k;
		int unsigned ins_pct;
		int unsigned rem_pct;

		// Reset once, released away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The empty table first: every operation that reads
		// the table must report empty and leave the count at zero.
		send_item(slt_pkg::OP_SEARCH, 32'sd7);
		send_item(slt_pkg::OP_REMOVE, 32'sd7);
		send_item(OP_UNUSED, 32'sd7);

		// Both extremes, zero, minus one and a repeated zero: the second zero
		// goes in front of the first one.
		send_item(slt_pkg::OP_INSERT, 32'sh7fff_ffff);
		send_item(slt_pkg::OP_INSERT, 32'sh8000_0000);
		send_item(slt_pkg::OP_INSERT, 32'sd0);
		send_item(slt_pkg::OP_INSERT, -32'sd1);
		send_item(slt_pkg::OP_INSERT, 32'sd0);

		// Searches at the ends and in the middle, one under the unused code.
		send_item(slt_pkg::OP_SEARCH, 32'sd0);
		send_item(slt_pkg::OP_SEARCH, 32'sh7fff_ffff);
		send_item(OP_UNUSED, 32'sh8000_0000);

		// Two misses on a table that is not empty, then a remove of a stored zero.
		send_item(slt_pkg::OP_REMOVE, 32'sd5);
		send_item(slt_pkg::OP_SEARCH, -32'sd5);
		send_item(slt_pkg::OP_REMOVE, 32'sd0);

		// Fill the table to the top, then one insert more must be refused.
		for (k = 0; k < slt_pkg::DEPTH - 4; k++) begin
			send_item(slt_pkg::OP_INSERT, $urandom);
		end
		send_item(slt_pkg::OP_INSERT, 32'sd1);
		send_item(slt_pkg::OP_SEARCH, 32'sh7fff_ffff);

		// Let the block run dry once before the random part.
		wait_for_responses();

		// Random part, in phases that fill, drain or churn the table so it
		// swings between empty and full many times.
		for (phase = 0; phase < PHASES; phase++) begin
			refresh_pool();
			case (phase % 3)
				0: begin
					ins_pct = 70;
					rem_pct = 15;
				end
				1: begin
					ins_pct = 40;
					rem_pct = 30;
				end
				default: begin
					ins_pct = 15;
					rem_pct = 60;
				end
			endcase
			if (phase >= PHASES - QUIET_LAST) begin
				send_gap_pct    = 0;
				ready_stall_pct = 0;
			end else begin
				send_gap_pct    = 20 * $urandom_range(2);
				ready_stall_pct = 20 * $urandom_range(2);
			end
			for (k = 0; k < PHASE_LEN; k++) begin
				send_item(pick_op(ins_pct, rem_pct), pick_value());
			end
			if (phase % 7 == 6) begin
				wait_for_responses();
			end
		end

		// All items are in; wait for the last responses and a little more so
		// that any stray response would still show up.
		wait_for_responses();
		repeat (12) @(negedge clk);

		if (fail_count == 0 && pending_count == 0) begin
			$display("sorted_list_table_tb OK");
		end else begin
			$display("sorted_list_table_tb NOT OK");
		end
		$finish;
	end

endmodule
